// ===== rtl/mqttp_pkg.sv =====
// ----------------------------------------------------------------------------
// mqttp_pkg
// Types, codes and constants shared by the packet byte parser modules.
// ----------------------------------------------------------------------------
package mqttp_pkg;

  localparam int LEN_W      = 28;
  localparam int SHIFT_W    = 5;
  localparam int DIGIT_BITS = 7;

  localparam logic [SHIFT_W-1:0] LEN_STEP    = SHIFT_W'(DIGIT_BITS);
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(LEN_W);

  localparam logic [7:0] DIGIT_MASK = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'h80;

  // control packet types that get a body walk
  localparam logic [3:0] PKT_CONNECT   = 4'd1;
  localparam logic [3:0] PKT_PUBLISH   = 4'd3;
  localparam logic [3:0] PKT_SUBSCRIBE = 4'd8;

  // connect flag bit positions
  localparam int CF_WILL = 2;
  localparam int CF_PASS = 6;
  localparam int CF_USER = 7;

  typedef enum logic [4:0] {
    PH_HDR     = 5'd0,
    PH_REM     = 5'd1,
    PH_UNP     = 5'd2,
    PH_PAY     = 5'd3,
    PH_VER     = 5'd4,
    PH_FLG     = 5'd5,
    PH_KAH     = 5'd6,
    PH_KAL     = 5'd7,
    PH_MIDH    = 5'd8,
    PH_MIDL    = 5'd9,
    PH_PROT_H  = 5'd10,
    PH_PROT_L  = 5'd11,
    PH_PROT_C  = 5'd12,
    PH_CID_H   = 5'd13,
    PH_CID_L   = 5'd14,
    PH_CID_C   = 5'd15,
    PH_WTOP_H  = 5'd16,
    PH_WTOP_L  = 5'd17,
    PH_WTOP_C  = 5'd18,
    PH_WMSG_H  = 5'd19,
    PH_WMSG_L  = 5'd20,
    PH_WMSG_C  = 5'd21,
    PH_USER_H  = 5'd22,
    PH_USER_L  = 5'd23,
    PH_USER_C  = 5'd24,
    PH_PASS_H  = 5'd25,
    PH_PASS_L  = 5'd26,
    PH_PASS_C  = 5'd27,
    PH_TOPIC_H = 5'd28,
    PH_TOPIC_L = 5'd29,
    PH_TOPIC_C = 5'd30
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HEADER   = 3'd0,
    ROLE_REMLEN   = 3'd1,
    ROLE_LEN_HIGH = 3'd2,
    ROLE_LEN_LOW  = 3'd3,
    ROLE_CONTENT  = 3'd4,
    ROLE_SINGLE   = 3'd5,
    ROLE_VAL_HIGH = 3'd6,
    ROLE_VAL_LOW  = 3'd7
  } role_t;

  typedef enum logic [3:0] {
    FID_NONE      = 4'd0,
    FID_PROTNAME  = 4'd1,
    FID_VERSION   = 4'd2,
    FID_FLAGS     = 4'd3,
    FID_KEEPALIVE = 4'd4,
    FID_CLIENTID  = 4'd5,
    FID_WILLTOPIC = 4'd6,
    FID_WILLMSG   = 4'd7,
    FID_USER      = 4'd8,
    FID_PASS      = 4'd9,
    FID_MSGID     = 4'd10,
    FID_TOPIC     = 4'd11,
    FID_PAYLOAD   = 4'd12,
    FID_UNPARSED  = 4'd13
  } field_t;

  typedef enum logic [1:0] {
    PART_HIGH = 2'd0,
    PART_LOW  = 2'd1,
    PART_BODY = 2'd2
  } str_part_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_packet;
  } in_beat_t;

  typedef struct packed {
    role_t             byte_role;
    field_t            field_id;
    logic [7:0]        byte_value;
    logic [3:0]        packet_type;
    logic              dup_flag;
    logic [1:0]        qos_level;
    logic              retain_flag;
    logic [LEN_W-1:0]  remaining_length;
    logic              value_ready;
    logic [15:0]       field_value;
    logic              packet_end;
    logic              malformed;
  } result_t;

endpackage

// ===== rtl/mqttp_if.sv =====
// ----------------------------------------------------------------------------
// mqttp_if
// Valid/ready channels for the stream bytes and for the tagged results.
// ----------------------------------------------------------------------------
interface mqttp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_packet;

  modport source (output valid, output data_byte, output start_of_packet, input ready);
  modport sink   (input valid, input data_byte, input start_of_packet, output ready);
endinterface

interface mqttp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [3:0]  field_id;
  logic [7:0]  byte_value;
  logic [3:0]  packet_type;
  logic        dup_flag;
  logic [1:0]  qos_level;
  logic        retain_flag;
  logic [27:0] remaining_length;
  logic        value_ready;
  logic [15:0] field_value;
  logic        packet_end;
  logic        malformed;

  modport source (
    output valid, output byte_role, output field_id, output byte_value,
    output packet_type, output dup_flag, output qos_level, output retain_flag,
    output remaining_length, output value_ready, output field_value,
    output packet_end, output malformed, input ready
  );
  modport sink (
    input valid, input byte_role, input field_id, input byte_value,
    input packet_type, input dup_flag, input qos_level, input retain_flag,
    input remaining_length, input value_ready, input field_value,
    input packet_end, input malformed, output ready
  );
endinterface

// ===== rtl/mqttp_in_stage.sv =====
// ----------------------------------------------------------------------------
// mqttp_in_stage
// Input register: holds one stream beat until the parser takes it.
// ----------------------------------------------------------------------------
module mqttp_in_stage import mqttp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mqttp_in_if.sink  stream,
  input  logic      take,
  output logic      beat_valid,
  output in_beat_t  beat
);

  assign stream.ready = !beat_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      beat.data_byte       <= stream.data_byte;
      beat.start_of_packet <= stream.start_of_packet;
    end
  end

endmodule

// ===== rtl/mqttp_parser.sv =====
// ----------------------------------------------------------------------------
// mqttp_parser
// Packet walk state and the per-byte tagging logic.
// ----------------------------------------------------------------------------
module mqttp_parser import mqttp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  in_beat_t beat,
  output result_t  result
);

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [LEN_W-1:0]   total_len, total_len_next;
  logic [SHIFT_W-1:0] length_shift, length_shift_next;
  logic [15:0]        string_left, string_left_next;
  logic [7:0]         value_high, value_high_next;
  logic [7:0]         conn_flags, conn_flags_next;
  logic [7:0]         header_byte, header_byte_next;

  logic [7:0]       b;
  logic             is_hdr;
  logic             shift_over;
  logic [LEN_W-1:0] digit;
  logic [LEN_W-1:0] total_sum;
  logic [LEN_W-1:0] left;
  logic [15:0]      len16;
  logic [15:0]      str_dec;
  logic             is_str;
  field_t           str_fid;
  str_part_t        str_part;
  phase_t           after_will;
  phase_t           after_str;
  phase_t           first_body;
  phase_t           phase_inc;

  role_t       role;
  field_t      fid;
  logic        vready;
  logic [15:0] fval;
  logic        pend;
  logic        bad;

  assign b          = beat.data_byte;
  assign is_hdr     = beat.start_of_packet || (phase == PH_HDR);
  assign shift_over = (length_shift >= SHIFT_LIMIT);
  assign digit      = {{(LEN_W-8){1'b0}}, b & DIGIT_MASK};
  assign total_sum  = total_len + (digit << length_shift);
  assign left       = (bytes_left != '0) ? bytes_left - LEN_W'(1) : '0;
  assign len16      = {value_high, b};
  assign str_dec    = string_left - 16'd1;
  assign phase_inc  = phase_t'(phase + 5'd1);

  // string phases: which string and which part of it
  always_comb begin
    is_str   = 1'b1;
    str_fid  = FID_NONE;
    str_part = PART_HIGH;
    unique case (phase)
      PH_PROT_H:  begin str_fid = FID_PROTNAME;  str_part = PART_HIGH; end
      PH_PROT_L:  begin str_fid = FID_PROTNAME;  str_part = PART_LOW;  end
      PH_PROT_C:  begin str_fid = FID_PROTNAME;  str_part = PART_BODY; end
      PH_CID_H:   begin str_fid = FID_CLIENTID;  str_part = PART_HIGH; end
      PH_CID_L:   begin str_fid = FID_CLIENTID;  str_part = PART_LOW;  end
      PH_CID_C:   begin str_fid = FID_CLIENTID;  str_part = PART_BODY; end
      PH_WTOP_H:  begin str_fid = FID_WILLTOPIC; str_part = PART_HIGH; end
      PH_WTOP_L:  begin str_fid = FID_WILLTOPIC; str_part = PART_LOW;  end
      PH_WTOP_C:  begin str_fid = FID_WILLTOPIC; str_part = PART_BODY; end
      PH_WMSG_H:  begin str_fid = FID_WILLMSG;   str_part = PART_HIGH; end
      PH_WMSG_L:  begin str_fid = FID_WILLMSG;   str_part = PART_LOW;  end
      PH_WMSG_C:  begin str_fid = FID_WILLMSG;   str_part = PART_BODY; end
      PH_USER_H:  begin str_fid = FID_USER;      str_part = PART_HIGH; end
      PH_USER_L:  begin str_fid = FID_USER;      str_part = PART_LOW;  end
      PH_USER_C:  begin str_fid = FID_USER;      str_part = PART_BODY; end
      PH_PASS_H:  begin str_fid = FID_PASS;      str_part = PART_HIGH; end
      PH_PASS_L:  begin str_fid = FID_PASS;      str_part = PART_LOW;  end
      PH_PASS_C:  begin str_fid = FID_PASS;      str_part = PART_BODY; end
      PH_TOPIC_H: begin str_fid = FID_TOPIC;     str_part = PART_HIGH; end
      PH_TOPIC_L: begin str_fid = FID_TOPIC;     str_part = PART_LOW;  end
      PH_TOPIC_C: begin str_fid = FID_TOPIC;     str_part = PART_BODY; end
      default:    is_str = 1'b0;
    endcase
  end

  always_comb begin
    if (conn_flags[CF_USER]) begin
      after_will = PH_USER_H;
    end else if (conn_flags[CF_PASS]) begin
      after_will = PH_PASS_H;
    end else begin
      after_will = PH_UNP;
    end
  end

  always_comb begin
    unique case (str_fid)
      FID_PROTNAME:  after_str = PH_VER;
      FID_CLIENTID:  after_str = conn_flags[CF_WILL] ? PH_WTOP_H : after_will;
      FID_WILLTOPIC: after_str = PH_WMSG_H;
      FID_WILLMSG:   after_str = after_will;
      FID_USER:      after_str = conn_flags[CF_PASS] ? PH_PASS_H : PH_UNP;
      FID_PASS:      after_str = PH_UNP;
      default:       after_str = (header_byte[2:1] != 2'd0) ? PH_MIDH : PH_PAY;
    endcase
  end

  always_comb begin
    unique case (header_byte[7:4])
      PKT_CONNECT:   first_body = PH_PROT_H;
      PKT_PUBLISH:   first_body = PH_TOPIC_H;
      PKT_SUBSCRIBE: first_body = PH_MIDH;
      default:       first_body = PH_UNP;
    endcase
  end

  // next state
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    total_len_next    = total_len;
    length_shift_next = length_shift;
    string_left_next  = string_left;
    value_high_next   = value_high;
    conn_flags_next   = conn_flags;
    header_byte_next  = header_byte;
    if (is_hdr) begin
      header_byte_next  = b;
      phase_next        = PH_REM;
      bytes_left_next   = '0;
      total_len_next    = '0;
      length_shift_next = '0;
      string_left_next  = '0;
      value_high_next   = '0;
    end else if (phase == PH_REM) begin
      if (shift_over) begin
        phase_next = PH_HDR;
      end else begin
        total_len_next    = total_sum;
        length_shift_next = length_shift + LEN_STEP;
        if ((b & CONT_MASK) == 8'd0) begin
          bytes_left_next = total_sum;
          phase_next      = (total_sum == '0) ? PH_HDR : first_body;
        end
      end
    end else begin
      if (is_str) begin
        unique case (str_part)
          PART_HIGH: begin
            value_high_next = b;
            phase_next      = phase_inc;
          end
          PART_LOW: begin
            if (len16 == 16'd0) begin
              phase_next = after_str;
            end else begin
              string_left_next = len16;
              phase_next       = phase_inc;
            end
          end
          PART_BODY: begin
            string_left_next = str_dec;
            if (str_dec == 16'd0) phase_next = after_str;
          end
          default: phase_next = PH_UNP;
        endcase
      end else begin
        unique case (phase)
          PH_VER:  phase_next = PH_FLG;
          PH_FLG: begin
            conn_flags_next = b;
            phase_next      = PH_KAH;
          end
          PH_KAH: begin
            value_high_next = b;
            phase_next      = PH_KAL;
          end
          PH_KAL:  phase_next = PH_CID_H;
          PH_MIDH: begin
            value_high_next = b;
            phase_next      = PH_MIDL;
          end
          PH_MIDL: phase_next = PH_PAY;
          PH_PAY:  phase_next = PH_PAY;
          default: phase_next = PH_UNP;
        endcase
      end
      bytes_left_next = left;
      if (left == '0) phase_next = PH_HDR;
    end
  end

  // outputs
  always_comb begin
    role   = ROLE_HEADER;
    fid    = FID_NONE;
    vready = 1'b0;
    fval   = 16'd0;
    pend   = 1'b0;
    bad    = 1'b0;
    if (is_hdr) begin
      role = ROLE_HEADER;
    end else if (phase == PH_REM) begin
      role = ROLE_REMLEN;
      if (shift_over) begin
        bad  = 1'b1;
        pend = 1'b1;
      end else if ((b & CONT_MASK) == 8'd0 && total_sum == '0) begin
        pend = 1'b1;
      end
    end else begin
      if (is_str) begin
        fid = str_fid;
        unique case (str_part)
          PART_HIGH: role = ROLE_LEN_HIGH;
          PART_LOW: begin
            role   = ROLE_LEN_LOW;
            vready = 1'b1;
            fval   = len16;
            bad    = ({{(LEN_W-16){1'b0}}, len16} > left);
          end
          PART_BODY: role = ROLE_CONTENT;
          default:   role = ROLE_CONTENT;
        endcase
      end else begin
        unique case (phase)
          PH_VER: begin
            role = ROLE_SINGLE; fid = FID_VERSION; vready = 1'b1; fval = {8'd0, b};
          end
          PH_FLG: begin
            role = ROLE_SINGLE; fid = FID_FLAGS; vready = 1'b1; fval = {8'd0, b};
          end
          PH_KAH: begin
            role = ROLE_VAL_HIGH; fid = FID_KEEPALIVE;
          end
          PH_KAL: begin
            role = ROLE_VAL_LOW; fid = FID_KEEPALIVE; vready = 1'b1; fval = len16;
          end
          PH_MIDH: begin
            role = ROLE_VAL_HIGH; fid = FID_MSGID;
          end
          PH_MIDL: begin
            role = ROLE_VAL_LOW; fid = FID_MSGID; vready = 1'b1; fval = len16;
          end
          PH_PAY: begin
            role = ROLE_CONTENT; fid = FID_PAYLOAD;
          end
          default: begin
            role = ROLE_CONTENT; fid = FID_UNPARSED;
          end
        endcase
      end
      pend = (left == '0);
    end
  end

  assign result.byte_role        = role;
  assign result.field_id         = fid;
  assign result.byte_value       = b;
  assign result.packet_type      = header_byte_next[7:4];
  assign result.dup_flag         = header_byte_next[3];
  assign result.qos_level        = header_byte_next[2:1];
  assign result.retain_flag      = header_byte_next[0];
  assign result.remaining_length = total_len_next;
  assign result.value_ready      = vready;
  assign result.field_value      = fval;
  assign result.packet_end       = pend;
  assign result.malformed        = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      bytes_left   <= '0;
      total_len    <= '0;
      length_shift <= '0;
      string_left  <= '0;
      value_high   <= '0;
      conn_flags   <= '0;
      header_byte  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      total_len    <= total_len_next;
      length_shift <= length_shift_next;
      string_left  <= string_left_next;
      value_high   <= value_high_next;
      conn_flags   <= conn_flags_next;
      header_byte  <= header_byte_next;
    end
  end

endmodule

// ===== rtl/mqttp_out_stage.sv =====
// ----------------------------------------------------------------------------
// mqttp_out_stage
// Result register: holds one tagged beat until the sink takes it.
// ----------------------------------------------------------------------------
module mqttp_out_stage import mqttp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        free,
  mqttp_out_if.source tags
);

  logic    res_valid;
  result_t res_q;

  assign free = !res_valid || tags.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (tags.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= result;
    end
  end

  assign tags.valid            = res_valid;
  assign tags.byte_role        = res_q.byte_role;
  assign tags.field_id         = res_q.field_id;
  assign tags.byte_value       = res_q.byte_value;
  assign tags.packet_type      = res_q.packet_type;
  assign tags.dup_flag         = res_q.dup_flag;
  assign tags.qos_level        = res_q.qos_level;
  assign tags.retain_flag      = res_q.retain_flag;
  assign tags.remaining_length = res_q.remaining_length;
  assign tags.value_ready      = res_q.value_ready;
  assign tags.field_value      = res_q.field_value;
  assign tags.packet_end       = res_q.packet_end;
  assign tags.malformed        = res_q.malformed;

endmodule

// ===== rtl/mqtt_packet_byte_parser.sv =====
// ----------------------------------------------------------------------------
// mqtt_packet_byte_parser
// Tags each byte of an MQTT stream with its field and role in the packet.
//
//   channel  dir  payload
//   stream   in   data_byte, start_of_packet
//   tags     out  byte_role, field_id, byte_value, header fields,
//                 remaining_length, value_ready, field_value, packet_end,
//                 malformed
//
// One byte per clock sustained while tags.ready stays high; each byte is held
// in the input register, then parsed into the result register.
// The parse state updates once per byte as it moves into the result register.
// A stalled result register holds the input register; the input side keeps
// taking beats while the result register can drain in the same cycle.
// rst is synchronous and returns the walk to expecting a fixed header.
// ----------------------------------------------------------------------------
module mqtt_packet_byte_parser import mqttp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mqttp_in_if.sink    stream,
  mqttp_out_if.source tags
);

  logic     beat_valid;
  in_beat_t beat;
  logic     free;
  logic     step;
  result_t  result;

  assign step = beat_valid && free;

  mqttp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .take       (step),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  mqttp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (beat),
    .result (result)
  );

  mqttp_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .result (result),
    .free   (free),
    .tags   (tags)
  );

endmodule
